// File: sv/huffman_code_bit_packer_core_macros.svh
// Assertion macros used by the Huffman code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hcbp_pkg.sv
// Package with the types and constants of the Huffman code bit packer.
package hcbp_pkg;

    localparam int SYMBOL_COUNT_DEFAULT    = 256;
    localparam int MAX_CODE_LENGTH_DEFAULT = 8;

    localparam int CMD_W    = 2;
    localparam int SYMBOL_W = 8;
    localparam int CODE_W   = 8;
    localparam int LEN_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    // One table entry as read back from the code table.
    typedef struct packed {
        logic              present;
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Item issued from the accept stage to the packing stage.
    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] command;
    } issue_t;

endpackage

// File: sv/hcbp_req_if.sv
// Request channel interface: commands, symbols and table entries.
interface hcbp_req_if;
    logic                          valid;
    logic                          ready;
    logic [hcbp_pkg::CMD_W-1:0]    command;
    logic [hcbp_pkg::SYMBOL_W-1:0] symbol;
    logic [hcbp_pkg::CODE_W-1:0]   code_bits;
    logic [hcbp_pkg::LEN_W-1:0]    code_length;
    logic                          entry_present;

    modport source (
        output valid, command, symbol, code_bits, code_length, entry_present,
        input  ready
    );

    modport sink (
        input  valid, command, symbol, code_bits, code_length, entry_present,
        output ready
    );
endinterface

// File: sv/hcbp_rsp_if.sv
// Response channel interface: packed bytes and missing-symbol flags.
interface hcbp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hcbp_pkg::CODE_W-1:0] out_byte;
    logic [hcbp_pkg::LEN_W-1:0]  bits_valid;
    logic                        symbol_missing;

    modport source (
        output valid, out_byte, bits_valid, symbol_missing,
        input  ready
    );

    modport sink (
        input  valid, out_byte, bits_valid, symbol_missing,
        output ready
    );
endinterface

// File: sv/hcbp_code_table.sv
// Code table: a synchronous memory of codes and lengths plus per-entry present bits.
module hcbp_code_table #(
    parameter int SYMBOL_COUNT    = hcbp_pkg::SYMBOL_COUNT_DEFAULT,
    parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [hcbp_pkg::SYMBOL_W-1:0] rd_symbol,
    input  logic                          wr_en,
    input  logic [hcbp_pkg::SYMBOL_W-1:0] wr_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   wr_code,
    input  logic [hcbp_pkg::LEN_W-1:0]    wr_length,
    input  logic                          wr_present,
    output hcbp_pkg::entry_t              lookup
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int WORD_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;
    localparam logic [hcbp_pkg::SYMBOL_W:0] LIMIT = (hcbp_pkg::SYMBOL_W + 1)'(SYMBOL_COUNT);
    localparam logic [hcbp_pkg::LEN_W-1:0]  MAX_LEN = hcbp_pkg::LEN_W'(MAX_CODE_LENGTH);

    logic [WORD_W-1:0]            mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]      present_reg;
    logic [WORD_W-1:0]            rd_word_reg;
    logic                         rd_present_reg;
    logic                         rd_in_range;
    logic                         wr_in_range;
    logic [ADDR_W-1:0]            rd_addr;
    logic [ADDR_W-1:0]            wr_addr;
    logic [hcbp_pkg::LEN_W-1:0]   wr_len_sat;
    logic [hcbp_pkg::CODE_W-1:0]  wr_code_masked;

    assign rd_in_range = {1'b0, rd_symbol} < LIMIT;
    assign wr_in_range = {1'b0, wr_symbol} < LIMIT;
    assign rd_addr     = rd_symbol[ADDR_W-1:0];
    assign wr_addr     = wr_symbol[ADDR_W-1:0];

    // Lengths saturate on the way in and code bits past the length are cleared,
    // so the packer can merge the stored code directly.
    assign wr_len_sat     = (wr_length > MAX_LEN) ? MAX_LEN : wr_length;
    assign wr_code_masked = wr_code & ~(8'hFF >> wr_len_sat);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr] <= {wr_len_sat, wr_code_masked};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                present_reg[wr_addr] <= wr_present;
            end
            if (rd_en)
            begin
                rd_present_reg <= rd_in_range && present_reg[rd_addr];
            end
        end
    end

    assign lookup.present = rd_present_reg;
    assign lookup.length  = rd_word_reg[WORD_W-1:hcbp_pkg::CODE_W];
    assign lookup.code    = rd_word_reg[hcbp_pkg::CODE_W-1:0];

endmodule

// File: sv/hcbp_packer.sv
// Packing stage: merges looked-up codes into the pending byte and holds the result register.
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hcbp_pkg::issue_t            issue,
    input  hcbp_pkg::entry_t            lookup,
    output logic                        advance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hcbp_pkg::CODE_W-1:0] out_byte,
    output logic [hcbp_pkg::LEN_W-1:0]  bits_valid,
    output logic                        symbol_missing
);

    localparam int CW = hcbp_pkg::CODE_W;
    localparam int LW = hcbp_pkg::LEN_W;
    localparam logic [LW-1:0] FULL = LW'(CW);

    hcbp_pkg::issue_t   stage_reg;
    logic [CW-1:0]      pending_byte_reg;
    logic [CW-1:0]      pending_byte_next;
    logic [2:0]         pending_count_reg;
    logic [2:0]         pending_count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CW-1:0]      out_byte_reg;
    logic [CW-1:0]      out_byte_next;
    logic [LW-1:0]      bits_valid_reg;
    logic [LW-1:0]      bits_valid_next;
    logic               missing_reg;
    logic               missing_next;
    logic [2*CW-1:0]    merged;
    logic [LW-1:0]      total;

    // The pipeline moves whenever the result register is free or being drained.
    assign advance = !out_valid_reg || out_ready;

    assign merged = {pending_byte_reg, {CW{1'b0}}}
                  | ({lookup.code, {CW{1'b0}}} >> pending_count_reg);
    assign total  = {1'b0, pending_count_reg} + lookup.length;

    always_comb
    begin
        pending_byte_next  = pending_byte_reg;
        pending_count_next = pending_count_reg;
        out_valid_next     = 1'b0;
        out_byte_next      = '0;
        bits_valid_next    = '0;
        missing_next       = 1'b0;
        if (stage_reg.valid)
        begin
            case (stage_reg.command)
                hcbp_pkg::CMD_ENCODE:
                begin
                    if (!lookup.present)
                    begin
                        out_valid_next = 1'b1;
                        missing_next   = 1'b1;
                    end
                    else if (total >= FULL)
                    begin
                        out_valid_next     = 1'b1;
                        out_byte_next      = merged[2*CW-1:CW];
                        bits_valid_next    = FULL;
                        pending_byte_next  = merged[CW-1:0];
                        pending_count_next = total[2:0];
                    end
                    else
                    begin
                        pending_byte_next  = merged[2*CW-1:CW];
                        pending_count_next = total[2:0];
                    end
                end
                hcbp_pkg::CMD_FLUSH:
                begin
                    if (pending_count_reg != 3'd0)
                    begin
                        out_valid_next     = 1'b1;
                        out_byte_next      = pending_byte_reg;
                        bits_valid_next    = {1'b0, pending_count_reg};
                        pending_byte_next  = '0;
                        pending_count_next = '0;
                    end
                end
                default:
                begin
                    pending_byte_next = pending_byte_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg         <= '0;
            pending_byte_reg  <= '0;
            pending_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else if (advance)
        begin
            stage_reg         <= issue;
            pending_byte_reg  <= pending_byte_next;
            pending_count_reg <= pending_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg   <= out_byte_next;
            bits_valid_reg <= bits_valid_next;
            missing_reg    <= missing_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign bits_valid     = bits_valid_reg;
    assign symbol_missing = missing_reg;

    `HCBP_ASSERT_SAME(a_pending_low_clear, 1'b1,
        (pending_byte_reg & (8'hFF >> pending_count_reg)) == 8'h00,
        "pending byte has stray bits below its count")
    `HCBP_ASSERT_SAME(a_missing_no_data, out_valid_reg && missing_reg,
        out_byte_reg == 8'h00 && bits_valid_reg == 4'd0,
        "missing-symbol result carries data")
    `HCBP_ASSERT_SAME(a_data_count_range, out_valid_reg && !missing_reg,
        bits_valid_reg != 4'd0 && bits_valid_reg <= FULL,
        "data result has an impossible bit count")
    `HCBP_ASSERT_NEXT(a_stall_holds_state, !advance,
        $stable(pending_byte_reg) && $stable(pending_count_reg) && $stable(stage_reg),
        "packer state changed while stalled")

endmodule

// File: sv/huffman_code_bit_packer_core.sv
// Top level of the Huffman code bit packer: code table memory feeding a packing stage.
//
// The block keeps a table of Huffman codes, one entry per symbol, in a synchronous
// memory with per-entry present bits, and packs the codes of a symbol stream into
// bytes with the first code bit in bit 7. A load item writes one entry (lengths above
// MAX_CODE_LENGTH are stored as MAX_CODE_LENGTH, code bits past the length are
// dropped, indexes at or above SYMBOL_COUNT are ignored). An encode item returns a
// full byte when eight bits have gathered, nothing otherwise, or a result with
// symbol_missing set when the symbol has no present entry. A flush item with bits
// pending returns the partial byte, zero padded, with its bit count, and clears the
// packer. The block takes one item every cycle unless a waiting result stalls it:
// an accepted item goes into the stage register and its table read into the read
// register, and the merge into the pending byte and the result register works from
// those. A load writes the table at its accept edge, so an encode of the same symbol
// right behind it already sees the new entry. The only thing that slows the input
// is a result left waiting in the result register; while it waits, nothing moves.
module huffman_code_bit_packer_core #(
    parameter int SYMBOL_COUNT    = hcbp_pkg::SYMBOL_COUNT_DEFAULT,
    parameter int MAX_CODE_LENGTH = hcbp_pkg::MAX_CODE_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    hcbp_req_if.sink    request,
    hcbp_rsp_if.source  response
);

    logic             advance;
    logic             accept;
    hcbp_pkg::issue_t issue;
    hcbp_pkg::entry_t lookup;

    // An item is taken whenever the packing stage can move forward.
    assign request.ready = advance;
    assign accept        = request.valid && advance;

    assign issue.valid   = accept;
    assign issue.command = request.command;

    // The table is written only by load items and read for every accepted item;
    // the packing stage ignores the lookup for anything but an encode.
    hcbp_code_table #(
        .SYMBOL_COUNT    (SYMBOL_COUNT),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (advance),
        .rd_symbol  (request.symbol),
        .wr_en      (accept && (request.command == hcbp_pkg::CMD_LOAD)),
        .wr_symbol  (request.symbol),
        .wr_code    (request.code_bits),
        .wr_length  (request.code_length),
        .wr_present (request.entry_present),
        .lookup     (lookup)
    );

    hcbp_packer u_packer (
        .clk            (clk),
        .rst_n          (rst_n),
        .issue          (issue),
        .lookup         (lookup),
        .advance        (advance),
        .out_valid      (response.valid),
        .out_ready      (response.ready),
        .out_byte       (response.out_byte),
        .bits_valid     (response.bits_valid),
        .symbol_missing (response.symbol_missing)
    );

endmodule

// File: sim/huffman_code_bit_packer_core_tb.sv
// Self-checking testbench for the Huffman code bit packer core.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;

    localparam int CMD_W    = hcbp_pkg::CMD_W;
    localparam int SYMBOL_W = hcbp_pkg::SYMBOL_W;
    localparam int CODE_W   = hcbp_pkg::CODE_W;
    localparam int LEN_W    = hcbp_pkg::LEN_W;

    // Command code 3 is not decoded by the block; it must be swallowed silently.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = hcbp_pkg::SYMBOL_COUNT_DEFAULT;
    localparam int CODE_MAX    = hcbp_pkg::MAX_CODE_LENGTH_DEFAULT;
    localparam int DRAIN_LIMIT = 2000;

    // One request item as it crosses the request channel.
    typedef struct {
        logic [CMD_W-1:0]    command;
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
        logic                entry_present;
    } huff_item_t;

    // One response item: a packed byte, its valid bit count and the missing flag.
    typedef struct packed {
        logic [CODE_W-1:0] data;
        logic [LEN_W-1:0]  nbits;
        logic              missing;
    } packed_out_t;

    logic clk;
    logic rst_n;

    hcbp_req_if req_ch ();
    hcbp_rsp_if rsp_ch ();

    huffman_code_bit_packer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // Shadow copy of the code table and of the packer registers.
    logic [CODE_W-1:0] shadow_code    [TABLE_DEPTH];
    logic [LEN_W-1:0]  shadow_len     [TABLE_DEPTH];
    logic              shadow_present [TABLE_DEPTH];
    logic [7:0]        shadow_pending_byte;
    logic [2:0]        shadow_pending_count;

    // Bytes and flags the block still owes us, oldest first.
    packed_out_t expected_bytes[$];

    int  error_count;
    bit  req_idle_on;
    bit  rsp_idle_on;

    // 4 ns clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #1_000_000;
        $display("huffman_code_bit_packer_core_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Advances the shadow packer by one accepted item and queues any result it causes.
    function automatic void predict_packed_output(input huff_item_t it);
        logic [3:0]  len;
        logic [7:0]  mask;
        logic [7:0]  code;
        logic [15:0] acc;
        logic [4:0]  total;
        packed_out_t res;
        case (it.command)
            hcbp_pkg::CMD_LOAD:
            begin
                // Lengths above the maximum are stored clamped.
                shadow_len[it.symbol]     = (it.code_length > CODE_MAX) ? 4'(CODE_MAX)
                                                                        : it.code_length;
                shadow_code[it.symbol]    = it.code_bits;
                shadow_present[it.symbol] = it.entry_present;
            end
            hcbp_pkg::CMD_ENCODE:
            begin
                if (!shadow_present[it.symbol]) begin
                    // Missing symbol: flagged result, packer untouched.
                    res = '{data: 8'h00, nbits: 4'd0, missing: 1'b1};
                    expected_bytes.push_back(res);
                end
                else begin
                    len   = shadow_len[it.symbol];
                    // Keep only the top len bits of the stored code.
                    mask  = ~(8'hFF >> len);
                    code  = shadow_code[it.symbol] & mask;
                    acc   = {shadow_pending_byte, 8'h00}
                          | ({code, 8'h00} >> shadow_pending_count);
                    total = 5'(shadow_pending_count) + 5'(len);
                    if (total >= 5'd8) begin
                        res = '{data: acc[15:8], nbits: 4'd8, missing: 1'b0};
                        expected_bytes.push_back(res);
                        shadow_pending_byte  = acc[7:0];
                        shadow_pending_count = 3'(total - 5'd8);
                    end
                    else begin
                        shadow_pending_byte  = acc[15:8];
                        shadow_pending_count = 3'(total);
                    end
                end
            end
            hcbp_pkg::CMD_FLUSH:
            begin
                if (shadow_pending_count != 3'd0) begin
                    res = '{data: shadow_pending_byte, nbits: 4'(shadow_pending_count),
                            missing: 1'b0};
                    expected_bytes.push_back(res);
                    shadow_pending_byte  = 8'h00;
                    shadow_pending_count = 3'd0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Watches both channels at each rising edge. Accepted requests are predicted
    // before accepted responses are checked, so a same-edge pair is still in order.
    // Values read here are the pre-edge values, since the block updates with
    // nonblocking assignments.
    always @(posedge clk) begin
        huff_item_t  seen;
        packed_out_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                seen.command       = req_ch.command;
                seen.symbol        = req_ch.symbol;
                seen.code_bits     = req_ch.code_bits;
                seen.code_length   = req_ch.code_length;
                seen.entry_present = req_ch.entry_present;
                predict_packed_output(seen);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("result items beyond those expected", 1, 0);
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (rsp_ch.out_byte !== want.data)
                        report_mismatch("out_byte", int'(rsp_ch.out_byte), int'(want.data));
                    if (rsp_ch.bits_valid !== want.nbits)
                        report_mismatch("bits_valid", int'(rsp_ch.bits_valid),
                                        int'(want.nbits));
                    if (rsp_ch.symbol_missing !== want.missing)
                        report_mismatch("symbol_missing", int'(rsp_ch.symbol_missing),
                                        int'(want.missing));
                end
            end
        end
    end

    // The receiver drops ready for random bursts while
    // rsp_idle_on is set, and keeps it high otherwise.
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else if (rsp_idle_on && $urandom_range(0, 6) == 0) begin
                rsp_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end
            else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Offers one item and returns at the rising edge where it is taken. Valid is
    // left high, so back-to-back items never glitch it low. A random idle gap, with
    // valid low, may come first while req_idle_on is set.
    task automatic send_item(input huff_item_t it);
        int gap;
        @(negedge clk);
        if (req_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.command       = it.command;
        req_ch.symbol        = it.symbol;
        req_ch.code_bits     = it.code_bits;
        req_ch.code_length   = it.code_length;
        req_ch.entry_present = it.entry_present;
        req_ch.valid         = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Lowers valid and waits until every expected result has come back or DRAIN_LIMIT is reached.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
    endtask

    function automatic huff_item_t make_item(input logic [CMD_W-1:0] cmd,
                                             input int sym, input int code,
                                             input int len, input bit present);
        huff_item_t it;
        it.command       = cmd;
        it.symbol        = SYMBOL_W'(sym);
        it.code_bits     = CODE_W'(code);
        it.code_length   = LEN_W'(len);
        it.entry_present = present;
        return it;
    endfunction

    // Mostly legal lengths, with some zero-length codes and some oversized ones.
    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        else if (r < 16)
            return $urandom_range(CODE_MAX + 1, 15);
        return $urandom_range(1, CODE_MAX);
    endfunction

    // Finds a symbol that currently has a present table entry, starting the scan
    // at a random point. Falls back to a random symbol when the table is empty.
    function automatic int pick_live_symbol();
        int start;
        int idx;
        start = $urandom_range(0, TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            idx = (start + i) % TABLE_DEPTH;
            if (shadow_present[idx])
                return idx;
        end
        return start;
    endfunction

    task automatic send_random_load(input int present_pct);
        send_item(make_item(hcbp_pkg::CMD_LOAD, $urandom_range(0, TABLE_DEPTH - 1),
                            $urandom_range(0, 255), random_length(),
                            $urandom_range(0, 99) < present_pct));
    endtask

    // Hand-picked items covering the field extremes, every command and the
    // corner cases of the packer: clamped lengths, junk code bits past the
    // length, zero-length codes, entries loaded as absent, never-loaded
    // symbols, a flush with a partial byte and a flush with nothing pending.
    task automatic test_directed_cases();
        send_item(make_item(hcbp_pkg::CMD_LOAD,   0,   8'hFF, 8,  1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 0,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_LOAD,   255, 8'hBF, 3,  1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 255, 0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 255, 0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 255, 0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_LOAD,   1,   8'hFF, 0,  1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 1,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_LOAD,   2,   8'hA5, 15, 1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 2,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_LOAD,   3,   8'h7F, 2,  1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 3,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_LOAD,   4,   8'hC0, 2,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 4,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 77,  0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_FLUSH,  0,   0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_FLUSH,  255, 8'hFF, 15, 1'b1));
        send_item(make_item(CMD_UNUSED,           255, 8'hFF, 15, 1'b1));
        send_item(make_item(hcbp_pkg::CMD_ENCODE, 255, 0,     0,  1'b0));
        send_item(make_item(hcbp_pkg::CMD_FLUSH,  0,   0,     0,  1'b0));
    endtask

    // Fills part of the table with random codes.
    task automatic test_table_fill(input int count);
        repeat (count) send_random_load(90);
    endtask

    // A symbol stream with random content: mostly encodes of present symbols,
    // plus reloads, flushes, missing symbols and the unused command as noise.
    // Idling on each side is switched on and off in stretches.
    task automatic test_random_stream(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                req_idle_on = ($urandom_range(0, 2) != 0);
                rsp_idle_on = ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 6)
                send_random_load(85);
            else if (r < 10)
                send_item(make_item(hcbp_pkg::CMD_FLUSH, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 15),
                                    1'($urandom_range(0, 1))));
            else if (r < 12)
                send_item(make_item(CMD_UNUSED, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 15),
                                    1'($urandom_range(0, 1))));
            else if (r < 20)
                send_item(make_item(hcbp_pkg::CMD_ENCODE, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 15),
                                    1'($urandom_range(0, 1))));
            else
                send_item(make_item(hcbp_pkg::CMD_ENCODE, pick_live_symbol(),
                                    $urandom_range(0, 255), $urandom_range(0, 15),
                                    1'($urandom_range(0, 1))));
        end
    endtask

    // The sender holds off until the block has returned everything, then resumes.
    task automatic test_sender_holdoff();
        test_random_stream(20);
        drain_results();
        test_random_stream(20);
    endtask

    // Final stretch at full rate on both sides, closed by a flush.
    task automatic test_full_rate_tail(input int count);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0)
                send_random_load(90);
            else
                send_item(make_item(hcbp_pkg::CMD_ENCODE, pick_live_symbol(),
                                    $urandom_range(0, 255), $urandom_range(0, 15),
                                    1'($urandom_range(0, 1))));
        end
        send_item(make_item(hcbp_pkg::CMD_FLUSH, 0, 0, 0, 1'b0));
    endtask

    initial begin
        error_count = 0;
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        shadow_pending_byte  = 8'h00;
        shadow_pending_count = 3'd0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_code[i]    = '0;
            shadow_len[i]     = '0;
            shadow_present[i] = 1'b0;
        end

        req_ch.valid         = 1'b0;
        req_ch.command       = hcbp_pkg::CMD_LOAD;
        req_ch.symbol        = '0;
        req_ch.code_bits     = '0;
        req_ch.code_length   = '0;
        req_ch.entry_present = 1'b0;

        // Reset asserted at the start, released away from the rising edge.
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_table_fill(48);
        test_random_stream(340);
        test_sender_holdoff();
        test_full_rate_tail(90);

        drain_results();
        if (expected_bytes.size() != 0)
            report_mismatch("result items still owed", expected_bytes.size(), 0);
        // Results reach the result register behind their items; give a few spare cycles
        // so any stray extra result would still be caught.
        repeat (6) @(negedge clk);

        if (error_count == 0)
            $display("huffman_code_bit_packer_core_tb: PASS");
        else
            $display("huffman_code_bit_packer_core_tb: FAIL");
        $finish;
    end

endmodule

// File: huffman_code_bit_packer_core.f
+incdir+sv
sv/hcbp_pkg.sv
sv/hcbp_req_if.sv
sv/hcbp_rsp_if.sv
sv/hcbp_code_table.sv
sv/hcbp_packer.sv
sv/huffman_code_bit_packer_core.sv
sim/huffman_code_bit_packer_core_tb.sv
